// ===== rtl/swdmte_pkg.sv =====
// Shared definitions for the SWD master transaction engine: command and ack
// codes, configuration register indexes, reset values and the result layout.
// No dependencies.
package swdmte_pkg;

    // Command codes carried in the command field of a command transaction.
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_RESET = 3'd2;
    localparam logic [2:0] CMD_J2S   = 3'd3;
    localparam logic [2:0] CMD_IDLE  = 3'd4;

    // Kind of an input transaction, carried in tuser.
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Acknowledge codes returned by the target.
    localparam logic [2:0] ACK_OK   = 3'd1;
    localparam logic [2:0] ACK_WAIT = 3'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
    localparam logic [1:0] CFG_WAIT_GAP    = 2'd1;
    localparam logic [1:0] CFG_RST_HIGH    = 2'd2;
    localparam logic [1:0] CFG_RST_LOW     = 2'd3;

    // Configuration reset values.
    localparam logic [3:0] RETRY_LIMIT_RST = 4'd8;
    localparam logic [3:0] WAIT_GAP_RST    = 4'd4;
    localparam logic [7:0] RST_HIGH_RST    = 8'd60;
    localparam logic [3:0] RST_LOW_RST     = 4'd4;

    // JTAG-to-SWD switching sequence, sent LSB first.
    localparam logic [15:0] J2S_SEQ = 16'hE79E;

    // One result transaction, packed LSB first into the 48-bit tdata.
    typedef struct packed {
        logic [6:0]  pad;
        logic        cmd_rejected;
        logic [31:0] read_data;
        logic [2:0]  ack;
        logic        done_res;
        logic        busy_res;
        logic        clock_active;
        logic        swdio_drive;
        logic        swdio_out;
    } result_t;

endpackage

// ===== rtl/swd_master_transaction_engine.sv =====
// SWD master transaction engine: top level with the protocol state machine,
// configuration registers and a two-entry output buffer.
// Depends on swdmte_pkg.
//
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tdata 48b command fields, tuser kind
// m_axis    out        tvalid/tready         tdata 48b pin and status result
// cfg       in         cfg_we (no wait)      cfg_addr index, cfg_wdata value
//
// Every input transaction has its result registered at the edge where it is
// accepted, so one transaction per clock is sustained while the buffer has room.
// The two-entry output buffer (output register plus skid register) keeps the
// input ready while a single result waits; only with both entries full is
// s_axis_tready dropped. Reset is synchronous and active low; it returns the
// engine to idle, restores the default configuration and empties the buffer.
module swd_master_transaction_engine
    import swdmte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input: [2:0] command, [3] ap_not_dp, [5:4] reg_addr, [37:6] write_data,
    // [45:38] idle_count, [46] swdio_in, [47] zero.
    input  logic [47:0] s_axis_tdata,
    // Input tuser: [0] req_type (0 command, 1 SWCLK tick).
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Result: [0] swdio_out, [1] swdio_drive, [2] clock_active, [3] busy_res,
    // [4] done_res, [7:5] ack, [39:8] read_data, [40] cmd_rejected, [47:41] zero.
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    // Protocol phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_REQ      = 4'd1;
    localparam logic [3:0] PH_TRN_A    = 4'd2;
    localparam logic [3:0] PH_ACK      = 4'd3;
    localparam logic [3:0] PH_RDATA    = 4'd4;
    localparam logic [3:0] PH_RPAR     = 4'd5;
    localparam logic [3:0] PH_TRN_B    = 4'd6;
    localparam logic [3:0] PH_WDATA    = 4'd7;
    localparam logic [3:0] PH_WPAR     = 4'd8;
    localparam logic [3:0] PH_GAP      = 4'd9;
    localparam logic [3:0] PH_RST_HIGH = 4'd10;
    localparam logic [3:0] PH_RST_LOW  = 4'd11;
    localparam logic [3:0] PH_J2S      = 4'd12;
    localparam logic [3:0] PH_IDLE_RUN = 4'd13;

    // Input fields.
    logic [2:0]  in_cmd;
    logic        in_ap;
    logic [1:0]  in_addr;
    logic [31:0] in_wdata;
    logic [7:0]  in_idle;
    logic        in_bit;

    assign in_cmd   = s_axis_tdata[2:0];
    assign in_ap    = s_axis_tdata[3];
    assign in_addr  = s_axis_tdata[5:4];
    assign in_wdata = s_axis_tdata[37:6];
    assign in_idle  = s_axis_tdata[45:38];
    assign in_bit   = s_axis_tdata[46];

    // Configuration registers.
    logic [3:0] retry_limit_reg;
    logic [3:0] wait_gap_reg;
    logic [7:0] rst_high_reg;
    logic [3:0] rst_low_reg;

    // Engine state. The latched request holds APnDP, RnW, A2, A3 and parity.
    logic [3:0]  phase_reg,   phase_next;
    logic [7:0]  cnt_reg,     cnt_next;
    logic [31:0] shift_reg,   shift_next;
    logic [4:0]  req_reg,     req_next;
    logic [31:0] wword_reg,   wword_next;
    logic [2:0]  ack_reg,     ack_next;
    logic [3:0]  attempt_reg, attempt_next;
    logic [31:0] rword_reg,   rword_next;

    // Output buffer.
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic       accept, pop;
    result_t    res;
    logic       dout, drive, clk, rejected, done;
    logic [7:0] cnt_inc, cnt_dec;
    logic [7:0] req_byte;
    logic [2:0] ack_or;
    logic [3:0] limit, attempt_inc;
    logic       rnw;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign cnt_inc     = 8'(cnt_reg + 8'd1);
    assign cnt_dec     = (cnt_reg != 8'd0) ? 8'(cnt_reg - 8'd1) : 8'd0;
    // Request byte on the wire: start, APnDP, RnW, A2, A3, parity, stop, park.
    assign req_byte    = {1'b1, 1'b0, req_reg, 1'b1};
    assign ack_or      = ack_reg | 3'({2'b00, in_bit} << cnt_reg[1:0]);
    assign limit       = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;
    assign attempt_inc = (attempt_reg < 4'd15) ? 4'(attempt_reg + 4'd1) : attempt_reg;
    assign rnw         = (in_cmd == CMD_READ);

    // One step of the engine for the transaction on the input.
    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        req_next     = req_reg;
        wword_next   = wword_reg;
        ack_next     = ack_reg;
        attempt_next = attempt_reg;
        rword_next   = rword_reg;
        dout         = 1'b0;
        drive        = 1'b0;
        clk          = 1'b0;
        rejected     = 1'b0;
        done         = 1'b0;

        if (s_axis_tuser == REQ_COMMAND) begin
            if (phase_reg != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                case (in_cmd)
                    CMD_READ, CMD_WRITE: begin
                        req_next     = {in_ap ^ rnw ^ in_addr[0] ^ in_addr[1],
                                        in_addr[1], in_addr[0], rnw, in_ap};
                        wword_next   = in_wdata;
                        attempt_next = 4'd0;
                        ack_next     = 3'd0;
                        shift_next   = 32'd0;
                        phase_next   = PH_REQ;
                        cnt_next     = 8'd0;
                    end
                    CMD_RESET: begin
                        ack_next = 3'd0;
                        if (rst_high_reg != 8'd0) begin
                            phase_next = PH_RST_HIGH;
                            cnt_next   = rst_high_reg;
                        end else if (rst_low_reg == 4'd0) begin
                            done = 1'b1;
                        end else begin
                            phase_next = PH_RST_LOW;
                            cnt_next   = {4'd0, rst_low_reg};
                        end
                    end
                    CMD_J2S: begin
                        ack_next   = 3'd0;
                        phase_next = PH_J2S;
                        cnt_next   = 8'd0;
                    end
                    CMD_IDLE: begin
                        ack_next = 3'd0;
                        cnt_next = in_idle;
                        if (in_idle != 8'd0) begin
                            phase_next = PH_IDLE_RUN;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        rejected = 1'b1;
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            clk = 1'b1;
            case (phase_reg)
                PH_REQ: begin
                    drive = 1'b1;
                    dout  = req_byte[cnt_reg[2:0]];
                    if (cnt_reg[2:0] == 3'd7) begin
                        phase_next = PH_TRN_A;
                        cnt_next   = 8'd0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_TRN_A: begin
                    phase_next = PH_ACK;
                    cnt_next   = 8'd0;
                end
                PH_ACK: begin
                    ack_next = ack_or;
                    if (cnt_reg == 8'd2) begin
                        cnt_next = 8'd0;
                        // Only a read that was accepted has a data phase here.
                        if (req_reg[1] && ack_or == ACK_OK) begin
                            phase_next = PH_RDATA;
                            shift_next = 32'd0;
                        end else begin
                            phase_next = PH_TRN_B;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_RDATA: begin
                    shift_next[cnt_reg[4:0]] = shift_reg[cnt_reg[4:0]] | in_bit;
                    if (cnt_reg[4:0] == 5'd31) begin
                        phase_next = PH_RPAR;
                        cnt_next   = 8'd0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_RPAR: begin
                    // The target's parity bit is not checked.
                    rword_next = shift_reg;
                    phase_next = PH_TRN_B;
                end
                PH_TRN_B: begin
                    if (ack_reg == ACK_OK) begin
                        if (!req_reg[1]) begin
                            phase_next = PH_WDATA;
                            cnt_next   = 8'd0;
                        end else begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end else if (ack_reg == ACK_WAIT && attempt_inc < limit) begin
                        attempt_next = attempt_inc;
                        if (wait_gap_reg != 4'd0) begin
                            phase_next = PH_GAP;
                            cnt_next   = {4'd0, wait_gap_reg};
                        end else begin
                            phase_next = PH_REQ;
                            cnt_next   = 8'd0;
                        end
                    end else begin
                        // Retries exhausted, or a fault or protocol error.
                        if (ack_reg == ACK_WAIT) begin
                            attempt_next = attempt_inc;
                        end
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_WDATA: begin
                    drive = 1'b1;
                    dout  = wword_reg[cnt_reg[4:0]];
                    if (cnt_reg[4:0] == 5'd31) begin
                        phase_next = PH_WPAR;
                        cnt_next   = 8'd0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_WPAR: begin
                    drive      = 1'b1;
                    dout       = ^wword_reg;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_GAP: begin
                    drive    = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        phase_next = PH_REQ;
                    end
                end
                PH_RST_HIGH: begin
                    drive    = 1'b1;
                    dout     = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        if (rst_low_reg == 4'd0) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_RST_LOW;
                            cnt_next   = {4'd0, rst_low_reg};
                        end
                    end
                end
                PH_RST_LOW, PH_IDLE_RUN: begin
                    drive    = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 8'd0) begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_J2S: begin
                    drive = 1'b1;
                    dout  = J2S_SEQ[cnt_reg[3:0]];
                    if (cnt_reg[3:0] == 4'd15) begin
                        phase_next = PH_IDLE;
                        cnt_next   = 8'd0;
                        done       = 1'b1;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    clk        = 1'b0;
                end
            endcase
        end

        res.pad          = 7'd0;
        res.cmd_rejected = rejected;
        res.read_data    = rword_next;
        res.ack          = done ? ack_next : 3'd0;
        res.done_res     = done;
        res.busy_res     = (phase_next != PH_IDLE);
        res.clock_active = clk;
        res.swdio_drive  = drive;
        res.swdio_out    = dout;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            wait_gap_reg    <= WAIT_GAP_RST;
            rst_high_reg    <= RST_HIGH_RST;
            rst_low_reg     <= RST_LOW_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_wdata[3:0];
                CFG_WAIT_GAP:    wait_gap_reg    <= cfg_wdata[3:0];
                CFG_RST_HIGH:    rst_high_reg    <= cfg_wdata;
                CFG_RST_LOW:     rst_low_reg     <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Engine state advances once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= 8'd0;
            shift_reg   <= 32'd0;
            req_reg     <= 5'd0;
            wword_reg   <= 32'd0;
            ack_reg     <= 3'd0;
            attempt_reg <= 4'd0;
            rword_reg   <= 32'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            shift_reg   <= shift_next;
            req_reg     <= req_next;
            wword_reg   <= wword_next;
            ack_reg     <= ack_next;
            attempt_reg <= attempt_next;
            rword_reg   <= rword_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    // A finished operation leaves the engine idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(out_reg.done_res && out_reg.busy_res))
        else $error("result reports done while still busy");

    // A rejected command never produces an SWCLK pulse.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(out_reg.cmd_rejected && out_reg.clock_active))
        else $error("rejected command issued a clock");

    // The skid entry is only filled behind a waiting output entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data with the output register empty");

    // An ack is only reported together with completion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_reg.ack != 3'd0) |-> out_reg.done_res)
        else $error("ack reported without completion");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the SWD master transaction engine.
// Drives command and SWCLK tick transactions, predicts every pin result in
// SystemVerilog and compares it field by field. Depends on swdmte_pkg.
`timescale 1ns / 100ps

module tb_top;
    import swdmte_pkg::*;

    // Run length guard, several times the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_SETTINGS = 5;
    localparam int ITEMS_PER_SETTING = 130;

    // Engine phases as the prediction tracks them.
    typedef enum logic [3:0] {
        ST_IDLE, ST_REQUEST, ST_TURN_A, ST_ACK, ST_RDATA, ST_RPARITY, ST_TURN_B,
        ST_WDATA, ST_WPARITY, ST_GAP, ST_RST_HIGH, ST_RST_LOW, ST_J2S, ST_IDLE_RUN
    } eng_phase_t;

    // Ack picking for a planned transaction: a fixed code or a random mix.
    localparam int ACK_RANDOM = -1;
    localparam logic [2:0] ACK_FAULT = 3'd4;

    // One input transaction, before packing onto the stream.
    typedef struct packed {
        logic        kind;
        logic [2:0]  command;
        logic        ap;
        logic [1:0]  addr;
        logic [31:0] wdata;
        logic [7:0]  idle;
        logic        swdio;
    } swd_item_t;

    typedef struct packed {
        logic [3:0] retry;
        logic [3:0] gap;
        logic [7:0] rhigh;
        logic [3:0] rlow;
    } swd_cfg_t;

    // Request bits held as: APnDP, RnW, A2, A3, parity from bit 0 up.
    typedef struct packed {
        eng_phase_t  ph;
        logic [7:0]  bitcnt;
        logic [31:0] shift;
        logic [4:0]  req;
        logic [31:0] wword;
        logic [2:0]  ackb;
        logic [3:0]  tries;
        logic [31:0] rword;
    } swd_engine_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;

    swd_master_transaction_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // The configuration as the engine holds it, the engine state seen at the
    // accepted transactions, and a planning copy used only to shape stimulus.
    swd_cfg_t    cfg_shadow = '{RETRY_LIMIT_RST, WAIT_GAP_RST, RST_HIGH_RST, RST_LOW_RST};
    swd_engine_t eng = '0;
    swd_engine_t plan = '0;

    swd_item_t   swd_items_q[$];
    result_t     predicted_pins_q[$];
    swd_item_t   cur_item = '0;

    int          cycle_cnt = 0;
    int          accept_cnt = 0;
    int          accept_seen = 0;
    int          result_cnt = 0;
    int          mismatches = 0;
    int          n_planned = 0;
    logic [2:0]  cur_ack = '0;
    bit          steady = 1'b0;
    bit          holdoff_go = 1'b0;
    bit          hold_rx = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Starts the low part of a line reset; returns 1 when nothing is left.
    function automatic bit enter_reset_low(inout swd_engine_t st, input swd_cfg_t c);
        if (c.rlow == 4'd0) begin
            st.ph = ST_IDLE;
            return 1'b1;
        end
        st.ph = ST_RST_LOW;
        st.bitcnt = {4'd0, c.rlow};
        return 1'b0;
    endfunction

    // Advances the engine by one transaction and returns the pin result.
    function automatic result_t swd_engine_step(inout swd_engine_t st, input swd_cfg_t c,
                                                input swd_item_t it);
        result_t    r;
        bit         fin;
        logic       rnw;
        logic [7:0] reqb;
        logic [3:0] lim;
        r = '0;
        fin = 1'b0;
        reqb = {1'b1, 1'b0, st.req, 1'b1};
        lim = (c.retry == 4'd0) ? 4'd1 : c.retry;
        if (it.kind == REQ_COMMAND) begin
            if (st.ph != ST_IDLE) begin
                r.cmd_rejected = 1'b1;
            end else begin
                case (it.command)
                    CMD_READ, CMD_WRITE: begin
                        rnw = (it.command == CMD_READ);
                        st.req = {it.ap ^ rnw ^ it.addr[0] ^ it.addr[1],
                                  it.addr[1], it.addr[0], rnw, it.ap};
                        st.wword = it.wdata;
                        st.tries = '0;
                        st.ackb = '0;
                        st.shift = '0;
                        st.ph = ST_REQUEST;
                        st.bitcnt = '0;
                    end
                    CMD_RESET: begin
                        st.ackb = '0;
                        if (c.rhigh != 8'd0) begin
                            st.ph = ST_RST_HIGH;
                            st.bitcnt = c.rhigh;
                        end else begin
                            fin = enter_reset_low(st, c);
                        end
                    end
                    CMD_J2S: begin
                        st.ackb = '0;
                        st.ph = ST_J2S;
                        st.bitcnt = '0;
                    end
                    CMD_IDLE: begin
                        st.ackb = '0;
                        st.bitcnt = it.idle;
                        if (it.idle != 8'd0) st.ph = ST_IDLE_RUN;
                        else fin = 1'b1;
                    end
                    default: r.cmd_rejected = 1'b1;
                endcase
            end
        end else if (st.ph != ST_IDLE) begin
            r.clock_active = 1'b1;
            case (st.ph)
                ST_REQUEST: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out = reqb[st.bitcnt[2:0]];
                    st.bitcnt = st.bitcnt + 8'd1;
                    if (st.bitcnt >= 8'd8) begin
                        st.ph = ST_TURN_A;
                        st.bitcnt = '0;
                    end
                end
                ST_TURN_A: begin
                    st.ph = ST_ACK;
                    st.bitcnt = '0;
                end
                ST_ACK: begin
                    st.ackb = st.ackb | ({2'b00, it.swdio} << st.bitcnt[1:0]);
                    st.bitcnt = st.bitcnt + 8'd1;
                    if (st.bitcnt >= 8'd3) begin
                        st.bitcnt = '0;
                        if (st.req[1] && st.ackb == ACK_OK) begin
                            st.ph = ST_RDATA;
                            st.shift = '0;
                        end else begin
                            st.ph = ST_TURN_B;
                        end
                    end
                end
                ST_RDATA: begin
                    st.shift = st.shift | ({31'd0, it.swdio} << st.bitcnt[4:0]);
                    st.bitcnt = st.bitcnt + 8'd1;
                    if (st.bitcnt >= 8'd32) begin
                        st.ph = ST_RPARITY;
                        st.bitcnt = '0;
                    end
                end
                ST_RPARITY: begin
                    // The read parity bit is clocked in but not checked.
                    st.rword = st.shift;
                    st.ph = ST_TURN_B;
                end
                ST_TURN_B: begin
                    st.ph = ST_IDLE;
                    fin = 1'b1;
                    if (st.ackb == ACK_OK) begin
                        if (!st.req[1]) begin
                            st.ph = ST_WDATA;
                            st.bitcnt = '0;
                            fin = 1'b0;
                        end
                    end else if (st.ackb == ACK_WAIT) begin
                        if (st.tries < 4'd15) st.tries = st.tries + 4'd1;
                        if (st.tries < lim) begin
                            fin = 1'b0;
                            if (c.gap != 4'd0) begin
                                st.ph = ST_GAP;
                                st.bitcnt = {4'd0, c.gap};
                            end else begin
                                st.ph = ST_REQUEST;
                                st.bitcnt = '0;
                            end
                        end
                    end
                end
                ST_WDATA: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out = st.wword[st.bitcnt[4:0]];
                    st.bitcnt = st.bitcnt + 8'd1;
                    if (st.bitcnt >= 8'd32) begin
                        st.ph = ST_WPARITY;
                        st.bitcnt = '0;
                    end
                end
                ST_WPARITY: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out = ^st.wword;
                    st.ph = ST_IDLE;
                    fin = 1'b1;
                end
                ST_GAP: begin
                    r.swdio_drive = 1'b1;
                    if (st.bitcnt != 8'd0) st.bitcnt = st.bitcnt - 8'd1;
                    if (st.bitcnt == 8'd0) begin
                        st.ph = ST_REQUEST;
                        st.bitcnt = '0;
                    end
                end
                ST_RST_HIGH: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out = 1'b1;
                    if (st.bitcnt != 8'd0) st.bitcnt = st.bitcnt - 8'd1;
                    if (st.bitcnt == 8'd0) fin = enter_reset_low(st, c);
                end
                ST_RST_LOW, ST_IDLE_RUN: begin
                    r.swdio_drive = 1'b1;
                    if (st.bitcnt != 8'd0) st.bitcnt = st.bitcnt - 8'd1;
                    if (st.bitcnt == 8'd0) begin
                        st.ph = ST_IDLE;
                        fin = 1'b1;
                    end
                end
                ST_J2S: begin
                    r.swdio_drive = 1'b1;
                    r.swdio_out = J2S_SEQ[st.bitcnt[3:0]];
                    st.bitcnt = st.bitcnt + 8'd1;
                    if (st.bitcnt >= 8'd16) begin
                        st.ph = ST_IDLE;
                        st.bitcnt = '0;
                        fin = 1'b1;
                    end
                end
                default: begin
                    st.ph = ST_IDLE;
                    r.clock_active = 1'b0;
                end
            endcase
        end
        r.busy_res = (st.ph != ST_IDLE);
        r.done_res = fin;
        r.ack = fin ? st.ackb : 3'd0;
        r.read_data = st.rword;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: acceptance is recorded and predicted at the rising edge,
    // the next transaction is put on the bus at the falling edge.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predicted_pins_q.push_back(swd_engine_step(eng, cfg_shadow, cur_item));
            accept_cnt <= accept_cnt + 1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || accept_cnt != accept_seen)) begin
            accept_seen = accept_cnt;
            if (swd_items_q.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                cur_item = swd_items_q.pop_front();
                s_axis_tdata <= {1'b0, cur_item.swdio, cur_item.idle, cur_item.wdata,
                                 cur_item.addr, cur_item.ap, cur_item.command};
                s_axis_tuser <= cur_item.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready is decided at the falling edge, results are taken
    // and checked at the rising edge against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR: result %0d, %s: got 0x%0h, predicted 0x%0h",
                 result_cnt, what, got, want);
        mismatches++;
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= aresetn && !hold_rx && (steady || $urandom_range(99) >= 20);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (predicted_pins_q.size() == 0) begin
                note_mismatch("result with nothing outstanding", got.read_data, '0);
            end else begin
                want = predicted_pins_q.pop_front();
                if (got.swdio_out !== want.swdio_out)
                    note_mismatch("swdio_out", got.swdio_out, want.swdio_out);
                if (got.swdio_drive !== want.swdio_drive)
                    note_mismatch("swdio_drive", got.swdio_drive, want.swdio_drive);
                if (got.clock_active !== want.clock_active)
                    note_mismatch("clock_active", got.clock_active, want.clock_active);
                if (got.busy_res !== want.busy_res)
                    note_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.done_res !== want.done_res)
                    note_mismatch("done_res", got.done_res, want.done_res);
                if (got.ack !== want.ack)
                    note_mismatch("ack", got.ack, want.ack);
                if (got.read_data !== want.read_data)
                    note_mismatch("read_data", got.read_data, want.read_data);
                if (got.cmd_rejected !== want.cmd_rejected)
                    note_mismatch("cmd_rejected", got.cmd_rejected, want.cmd_rejected);
                if (got.pad !== want.pad)
                    note_mismatch("padding", got.pad, want.pad);
            end
            result_cnt++;
        end
    end

    // The long hold-off: the receiver stops taking results while the sender
    // keeps offering, so the two-entry output buffer fills and s_axis_tready
    // has to fall.
    initial begin
        while (!holdoff_go) @(posedge aclk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------

    function automatic swd_item_t mk_item(logic kind, logic [2:0] cmd, logic ap,
                                          logic [1:0] addr, logic [31:0] wd,
                                          logic [7:0] cnt);
        swd_item_t it;
        it.kind = kind;
        it.command = cmd;
        it.ap = ap;
        it.addr = addr;
        it.wdata = wd;
        it.idle = cnt;
        it.swdio = 1'($urandom_range(1));
        return it;
    endfunction

    // Fields a tick ignores are filled at random so that every bit moves.
    function automatic swd_item_t tick_item();
        return mk_item(REQ_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)),
                       2'($urandom_range(3)), $urandom, 8'($urandom_range(255)));
    endfunction

    function automatic logic [2:0] pick_ack(int choice);
        int roll;
        if (choice != ACK_RANDOM) return 3'(choice);
        roll = $urandom_range(99);
        if (roll < 50) return ACK_OK;
        if (roll < 75) return ACK_WAIT;
        if (roll < 87) return ACK_FAULT;
        return 3'($urandom_range(7));
    endfunction

    // Queues one transaction and moves the planning copy along with it.
    task automatic add_item(input swd_item_t it, input bit counted);
        swd_items_q.push_back(it);
        void'(swd_engine_step(plan, cfg_shadow, it));
        if (counted) n_planned++;
    endtask

    // Queues a command and then the ticks that carry its operation through
    // to the end. During the ack phase the target answers with the chosen
    // code; commands sent while busy are sprinkled in at noise_pct percent.
    task automatic run_op(input swd_item_t cmd_item, input int ack_choice,
                          input int noise_pct);
        swd_item_t t;
        int guard;
        add_item(cmd_item, 1'b1);
        guard = 0;
        while (plan.ph != ST_IDLE && guard < 5000) begin
            t = tick_item();
            if (plan.ph == ST_ACK) begin
                if (plan.bitcnt == 8'd0) cur_ack = pick_ack(ack_choice);
                t.swdio = cur_ack[plan.bitcnt[1:0]];
            end
            add_item(t, 1'b1);
            if (plan.ph != ST_IDLE && $urandom_range(99) < noise_pct)
                add_item(mk_item(REQ_COMMAND, 3'($urandom_range(7)), 1'($urandom_range(1)),
                                 2'($urandom_range(3)), $urandom,
                                 8'($urandom_range(255))), 1'b0);
            guard++;
        end
    endtask

    // Waits until every transaction has been taken and every result checked.
    task automatic drain();
        while (swd_items_q.size() != 0 || s_axis_tvalid || predicted_pins_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all four registers with the engine idle.
    task automatic next_setting(input logic [3:0] retry, input logic [3:0] gap,
                                input logic [7:0] rhigh, input logic [3:0] rlow);
        drain();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_RETRY_LIMIT;
        cfg_wdata <= {4'd0, retry};
        @(negedge aclk);
        cfg_addr <= CFG_WAIT_GAP;
        cfg_wdata <= {4'd0, gap};
        @(negedge aclk);
        cfg_addr <= CFG_RST_HIGH;
        cfg_wdata <= rhigh;
        @(negedge aclk);
        cfg_addr <= CFG_RST_LOW;
        cfg_wdata <= {4'd0, rlow};
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_shadow = '{retry, gap, rhigh, rlow};
        plan = eng;
    endtask

    // One randomly chosen operation; transactions dominate, the rest are
    // the other operations plus noise that the engine should ignore.
    task automatic random_op();
        int roll;
        logic [7:0] cnt;
        roll = $urandom_range(99);
        if (roll < 70) begin
            run_op(mk_item(REQ_COMMAND, ($urandom_range(1) != 0) ? CMD_READ : CMD_WRITE,
                           1'($urandom_range(1)), 2'($urandom_range(3)), $urandom,
                           8'($urandom_range(255))), ACK_RANDOM, 3);
        end else if (roll < 80) begin
            cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
            run_op(mk_item(REQ_COMMAND, CMD_IDLE, 1'($urandom_range(1)),
                           2'($urandom_range(3)), $urandom, cnt), ACK_RANDOM, 3);
        end else if (roll < 86) begin
            run_op(mk_item(REQ_COMMAND, CMD_J2S, 1'($urandom_range(1)),
                           2'($urandom_range(3)), $urandom, 8'($urandom_range(255))),
                   ACK_RANDOM, 3);
        end else if (roll < 89) begin
            run_op(mk_item(REQ_COMMAND, CMD_RESET, 1'($urandom_range(1)),
                           2'($urandom_range(3)), $urandom, 8'($urandom_range(255))),
                   ACK_RANDOM, 3);
        end else if (roll < 95) begin
            add_item(mk_item(REQ_COMMAND, 3'($urandom_range(5, 7)), 1'($urandom_range(1)),
                             2'($urandom_range(3)), $urandom, 8'($urandom_range(255))),
                     1'b0);
        end else begin
            add_item(tick_item(), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        int k;
        int stop_at;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        plan = eng;

        // Directed part with the reset configuration: a tick with nothing to
        // do, unknown commands, an empty idle run and one of length one, reads and
        // writes at the field extremes with each kind of ack, the switching
        // sequence and a full line reset.
        add_item(tick_item(), 1'b1);
        add_item(mk_item(REQ_COMMAND, 3'd5, 1'b0, 2'd0, '0, '0), 1'b1);
        add_item(mk_item(REQ_COMMAND, 3'd7, 1'b1, 2'd3, '1, '1), 1'b1);
        run_op(mk_item(REQ_COMMAND, CMD_IDLE, 1'b0, 2'd0, '0, 8'd0), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_IDLE, 1'b1, 2'd1, '1, 8'd1), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_READ, 1'b1, 2'd3, $urandom, '0), ACK_OK, 10);
        run_op(mk_item(REQ_COMMAND, CMD_WRITE, 1'b0, 2'd0, 32'hFFFF_FFFF, '0), ACK_OK, 0);
        run_op(mk_item(REQ_COMMAND, CMD_WRITE, 1'b1, 2'd1, 32'h0000_0000, '0),
               ACK_FAULT, 0);
        run_op(mk_item(REQ_COMMAND, CMD_READ, 1'b0, 2'd2, $urandom, '0), ACK_WAIT, 0);
        run_op(mk_item(REQ_COMMAND, CMD_READ, 1'b1, 2'd0, $urandom, '0), 0, 0);
        run_op(mk_item(REQ_COMMAND, CMD_J2S, 1'b0, 2'd0, $urandom, '0), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_RESET, 1'b0, 2'd0, $urandom, '0), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_WRITE, 1'b0, 2'd2, $urandom, '0), ACK_OK, 0);

        // All registers at zero: the line reset ends on its own command, a
        // retry limit of zero behaves as one, and an ack of all ones is a
        // protocol error.
        next_setting(4'd0, 4'd0, 8'd0, 4'd0);
        run_op(mk_item(REQ_COMMAND, CMD_RESET, 1'b1, 2'd1, $urandom, '0), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_READ, 1'b1, 2'd2, $urandom, '0), ACK_WAIT, 0);
        run_op(mk_item(REQ_COMMAND, CMD_WRITE, 1'b0, 2'd1, $urandom, '0), 7, 0);

        // Retries with no gap clocks, and a line reset with only its low part.
        next_setting(4'd3, 4'd0, 8'd0, 4'd15);
        run_op(mk_item(REQ_COMMAND, CMD_READ, 1'b0, 2'd3, $urandom, '0), ACK_WAIT, 0);
        run_op(mk_item(REQ_COMMAND, CMD_RESET, 1'b0, 2'd0, $urandom, '0), ACK_RANDOM, 0);
        run_op(mk_item(REQ_COMMAND, CMD_WRITE, 1'b1, 2'd3, $urandom, '0), ACK_OK, 0);

        // Random part over several settings, the register extremes first.
        for (k = 0; k < RANDOM_SETTINGS; k++) begin
            case (k)
                0: next_setting(4'd15, 4'd15, 8'd255, 4'd15);
                1: next_setting(4'd1, 4'd0, 8'd50, 4'd0);
                default: next_setting(4'($urandom_range(1, 15)), 4'($urandom_range(15)),
                                      8'($urandom_range(50, 255)), 4'($urandom_range(15)));
            endcase
            stop_at = n_planned + ITEMS_PER_SETTING;
            while (n_planned < stop_at) random_op();
            // Back-pressure during the second setting, and a stretch with
            // neither side idling during the third.
            if (k == 1) holdoff_go = 1'b1;
            steady = (k == 2);
            drain();
            steady = 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/swdmte_pkg.sv
rtl/swd_master_transaction_engine.sv
bench/tb_top.sv
